// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the frame receiver RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define CFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define CFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cfr_pkg.sv -----
// Package for the command frame receiver: protocol codes, default sizes
// and the result record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

    // Frame protocol codes
    localparam logic [7:0] HDR_BYTE  = 8'hA0;
    localparam logic [7:0] CMD_RESET = 8'hA1;
    localparam logic [7:0] CMD_DONE  = 8'h1A;

    // Position of the length high byte within a frame
    localparam int unsigned LEN_HIGH_POS = 3;

    // Default frame buffer size in bytes
    localparam int unsigned BUFFER_SIZE_DEF = 1024;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned LEN_W   = 16;

    // One result, as it travels to the output stage
    typedef struct packed {
        logic               store_enable;
        logic [INDEX_W-1:0] store_index;
        logic [BYTE_W-1:0]  store_byte;
        logic               reset_request;
        logic               frame_ready;
        logic               download_done;
        logic [LEN_W-1:0]   payload_length;
    } cfr_result_t;

endpackage

`default_nettype wire

// ----- rtl/cfr_if.sv -----
// Valid/ready channel interfaces for received bytes and frame results.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_out_if;
    logic        valid;
    logic        ready;
    logic        store_enable;
    logic [9:0]  store_index;
    logic [7:0]  store_byte;
    logic        reset_request;
    logic        frame_ready;
    logic        download_done;
    logic [15:0] payload_length;

    modport source (
        output valid, output store_enable, output store_index, output store_byte,
        output reset_request, output frame_ready, output download_done,
        output payload_length, input ready
    );
    modport sink (
        input valid, input store_enable, input store_index, input store_byte,
        input reset_request, input frame_ready, input download_done,
        input payload_length, output ready
    );
endinterface

`default_nettype wire

// ----- rtl/command_frame_receiver_unit.sv -----
// Command frame receiver: one received byte in, one result out per transaction.
// Byte n is handled in the cycle it is accepted and its result is registered
// in the output stage, so the block takes a byte every clock while the output
// stage has room to take it. A two-entry output stage lets one more byte be
// accepted while the result side stalls. Frames are header 0xA0, command,
// 16-bit little-endian length and payload; frame bytes are written out with
// their buffer position.
// Depends on cfr_pkg, cfr_if, cfr_out_stage and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module command_frame_receiver_unit
    import cfr_pkg::*;
#(
    parameter int unsigned BUFFER_SIZE = BUFFER_SIZE_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    cfr_in_if.sink    rx_bytes,
    cfr_out_if.source results
);

    // Position counter must hold the buffer size itself
    localparam int unsigned PW   = $clog2(BUFFER_SIZE + 1);
    localparam int unsigned CMPW = (PW > LEN_W) ? PW : LEN_W;
    localparam int unsigned IXW  = (PW > INDEX_W) ? PW : INDEX_W;

    logic [PW-1:0]     pos_reg, pos_next;
    logic              in_frame_reg, in_frame_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              ready_flag_reg, ready_flag_next;
    logic              done_flag_reg, done_flag_next;
    logic [BYTE_W-1:0] cmd_reg;
    logic [BYTE_W-1:0] len_low_reg;

    logic              accept;
    logic              push_ready;
    logic [BYTE_W-1:0] rx;
    logic              wrap;
    logic [PW-1:0]     pos0;
    logic              inf0;
    logic [LEN_W-1:0]  len0;
    logic              rdy0;
    logic              done0;
    logic              hdr;
    logic [LEN_W-1:0]  len1;
    logic [PW-1:0]     pos_less3;
    logic              frame_end;
    logic              end_reset;
    logic              end_done;
    logic [IXW-1:0]    pos_ext;
    cfr_result_t       result;

    assign rx                = rx_bytes.rx_byte;
    assign rx_bytes.ready    = push_ready;
    assign accept            = rx_bytes.valid && push_ready;

    // Clear everything once the position has reached the buffer size
    always_comb
    begin
        wrap  = (pos_reg >= PW'(BUFFER_SIZE));
        pos0  = wrap ? '0 : pos_reg;
        inf0  = wrap ? 1'b0 : in_frame_reg;
        len0  = wrap ? '0 : len_reg;
        rdy0  = wrap ? 1'b0 : ready_flag_reg;
        done0 = wrap ? 1'b0 : done_flag_reg;
    end

    // Header detection, length load and frame end
    always_comb
    begin
        hdr       = (rx == HDR_BYTE) && !inf0;
        pos_less3 = pos0 - PW'(LEN_HIGH_POS);
        if (hdr)
        begin
            len1 = '0;
        end
        else if (inf0 && (pos0 == PW'(LEN_HIGH_POS)))
        begin
            len1 = {rx, len_low_reg};
        end
        else
        begin
            len1 = len0;
        end
        frame_end = inf0 && (pos0 >= PW'(LEN_HIGH_POS))
                    && (CMPW'(len1) == CMPW'(pos_less3));
        end_reset = frame_end && (cmd_reg == CMD_RESET);
        end_done  = frame_end && (cmd_reg == CMD_DONE);
    end

    // Next state
    always_comb
    begin
        in_frame_next   = frame_end ? 1'b0 : (inf0 || hdr);
        len_next        = frame_end ? '0 : len1;
        pos_next        = ((frame_end || hdr) ? '0 : pos0) + PW'(1);
        ready_flag_next = rdy0 || (frame_end && !end_reset && !end_done);
        done_flag_next  = (hdr ? 1'b0 : done0) || end_done;
    end

    // Assemble the result
    always_comb
    begin
        pos_ext               = IXW'(pos0);
        result.store_enable   = inf0 || hdr;
        result.store_index    = inf0 ? pos_ext[INDEX_W-1:0] : '0;
        result.store_byte     = (inf0 || hdr) ? rx : '0;
        result.reset_request  = end_reset;
        result.frame_ready    = ready_flag_next;
        result.download_done  = done_flag_next;
        result.payload_length = len_next;
    end

    // Hold frame state, advance on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            in_frame_reg   <= 1'b0;
            len_reg        <= '0;
            ready_flag_reg <= 1'b0;
            done_flag_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg        <= pos_next;
            in_frame_reg   <= in_frame_next;
            len_reg        <= len_next;
            ready_flag_reg <= ready_flag_next;
            done_flag_reg  <= done_flag_next;
        end
    end

    // Capture command and length low byte at their frame positions
    always_ff @(posedge clk)
    begin
        if (accept && inf0 && (pos0 == PW'(1)))
        begin
            cmd_reg <= rx;
        end
        if (accept && inf0 && (pos0 == PW'(2)))
        begin
            len_low_reg <= rx;
        end
    end

    cfr_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (rx_bytes.valid),
        .push_ready (push_ready),
        .push_data  (result),
        .res        (results)
    );

    // Position never runs past the buffer size
    `CFR_ASSERT(a_pos_bound, clk, rst_n, pos_reg <= PW'(BUFFER_SIZE), "byte position beyond buffer size")
    // Length register is only live inside a frame
    `CFR_ASSERT(a_len_idle_zero, clk, rst_n, !in_frame_reg |-> (len_reg == '0), "length held outside a frame")
    // Inside a frame the next byte never sits at position zero
    `CFR_ASSERT(a_frame_pos, clk, rst_n, in_frame_reg |-> (pos_reg != '0), "frame open at position zero")
    // A header outside a frame opens one with the command next
    `CFR_ASSERT(a_hdr_opens, clk, rst_n, (accept && hdr) |=> (in_frame_reg && (pos_reg == PW'(1))), "header did not open a frame")

endmodule

`default_nettype wire

// ----- rtl/cfr_out_stage.sv -----
// Two-entry result stage: result register plus skid register.
// Depends on cfr_pkg, cfr_if and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cfr_out_stage
    import cfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push_valid,
    output logic             push_ready,
    input  wire cfr_result_t push_data,
    cfr_out_if.source        res
);

    logic        main_valid_reg;
    logic        skid_valid_reg;
    cfr_result_t main_reg;
    cfr_result_t skid_reg;
    logic        push_fire;

    // Take a new transaction whenever the skid slot is free
    assign push_ready = !skid_valid_reg;
    assign push_fire  = push_valid && push_ready;

    // Advance the result register, park a transaction in the skid slot on a stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (res.ready || !main_valid_reg)
        begin
            main_valid_reg <= skid_valid_reg || push_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (push_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload moves alongside, no reset needed
    always_ff @(posedge clk)
    begin
        if (res.ready || !main_valid_reg)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push_fire)
        begin
            skid_reg <= push_data;
        end
    end

    // Drive the output channel
    assign res.valid          = main_valid_reg;
    assign res.store_enable   = main_reg.store_enable;
    assign res.store_index    = main_reg.store_index;
    assign res.store_byte     = main_reg.store_byte;
    assign res.reset_request  = main_reg.reset_request;
    assign res.frame_ready    = main_reg.frame_ready;
    assign res.download_done  = main_reg.download_done;
    assign res.payload_length = main_reg.payload_length;

    // A parked transaction always has one ahead of it
    `CFR_ASSERT(a_skid_behind_main, clk, rst_n, skid_valid_reg |-> main_valid_reg, "skid full with result register empty")
    // A stalled result plus a new transaction fills the skid slot
    `CFR_ASSERT(a_stall_parks, clk, rst_n, (main_valid_reg && !res.ready && push_fire) |=> skid_valid_reg, "stalled transaction not parked")
    // Draining the skid slot refills the result register
    `CFR_ASSERT(a_skid_drains, clk, rst_n, (skid_valid_reg && res.ready) |=> (main_valid_reg && !skid_valid_reg), "skid slot not drained")

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for command_frame_receiver_unit: drives received bytes,
// predicts every result and compares on the result channel.
// Depends on cfr_pkg, cfr_if and the RTL of the receiver.
`timescale 1ns / 1ps

module testbench;
    import cfr_pkg::*;

    localparam int unsigned BUF_BYTES     = BUFFER_SIZE_DEF;
    localparam int          TOTAL_ITEMS   = 1100;
    localparam int          CALM_TAIL     = 30;
    localparam int          STALL_LIMIT   = 1000;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          MAX_REPORTS   = 10;

    // One row of the directed sequence; a pinned row carries its result typed in
    typedef struct {
        logic [7:0]  rx;
        bit          pinned;
        cfr_result_t res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cfr_in_if  rx_if ();
    cfr_out_if res_if ();

    command_frame_receiver_unit #(
        .BUFFER_SIZE(BUF_BYTES)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_bytes (rx_if),
        .results  (res_if)
    );

    // Deframer state as the block should hold it
    logic [10:0] rx_pos       = '0;
    bit          frame_open   = 1'b0;
    logic [7:0]  frame_cmd    = '0;
    logic [7:0]  len_lsb      = '0;
    logic [15:0] frame_len    = '0;
    bit          ready_sticky = 1'b0;
    bit          done_sticky  = 1'b0;

    cfr_result_t deframed_q[$];
    int          bytes_sent  = 0;
    int          bad_results = 0;
    int          quiet_cycles = 0;
    bit          idling_on   = 1'b1;

    // Directed sequence: command types, zero length, header as data, 0xFFFF length
    dir_row_t directed_rows [24] = '{
        '{8'h00,     1'b1, '{1'b0, 10'd0, 8'h00,     1'b0, 1'b0, 1'b0, 16'h0000}},
        '{8'hFF,     1'b1, '{1'b0, 10'd0, 8'h00,     1'b0, 1'b0, 1'b0, 16'h0000}},
        '{HDR_BYTE,  1'b1, '{1'b1, 10'd0, HDR_BYTE,  1'b0, 1'b0, 1'b0, 16'h0000}},
        '{CMD_DONE,  1'b0, '0},
        '{8'h00,     1'b0, '0},
        '{8'h00,     1'b1, '{1'b1, 10'd3, 8'h00,     1'b0, 1'b0, 1'b1, 16'h0000}},
        '{HDR_BYTE,  1'b1, '{1'b1, 10'd0, HDR_BYTE,  1'b0, 1'b0, 1'b0, 16'h0000}},
        '{CMD_RESET, 1'b0, '0},
        '{8'h02,     1'b0, '0},
        '{8'h00,     1'b0, '0},
        '{HDR_BYTE,  1'b0, '0},
        '{8'hFF,     1'b1, '{1'b1, 10'd5, 8'hFF,     1'b1, 1'b0, 1'b0, 16'h0000}},
        '{8'h55,     1'b0, '0},
        '{HDR_BYTE,  1'b0, '0},
        '{8'h42,     1'b0, '0},
        '{8'h01,     1'b0, '0},
        '{8'h00,     1'b0, '0},
        '{8'h00,     1'b1, '{1'b1, 10'd4, 8'h00,     1'b0, 1'b1, 1'b0, 16'h0000}},
        '{HDR_BYTE,  1'b0, '0},
        '{8'hFF,     1'b0, '0},
        '{8'hFF,     1'b0, '0},
        '{8'hFF,     1'b1, '{1'b1, 10'd3, 8'hFF,     1'b0, 1'b1, 1'b0, 16'hFFFF}},
        '{8'h00,     1'b0, '0},
        '{HDR_BYTE,  1'b0, '0}
    };

    // Advance the deframer state by one byte and return the result it causes
    function cfr_result_t deframe_byte(input logic [7:0] b);
        cfr_result_t r;
        r = '0;
        // Clear everything once the buffer is full
        if (rx_pos >= BUF_BYTES) begin
            rx_pos       = '0;
            frame_open   = 1'b0;
            frame_len    = '0;
            ready_sticky = 1'b0;
            done_sticky  = 1'b0;
        end
        // Store bytes inside a frame and capture command and length low byte
        if (frame_open) begin
            r.store_enable = 1'b1;
            r.store_index  = rx_pos[INDEX_W-1:0];
            r.store_byte   = b;
            if (rx_pos == 1)
                frame_cmd = b;
            else if (rx_pos == 2)
                len_lsb = b;
        end
        // Open a frame on a header outside one, else load the length
        if (b == HDR_BYTE && !frame_open) begin
            rx_pos         = '0;
            frame_len      = '0;
            frame_open     = 1'b1;
            done_sticky    = 1'b0;
            r.store_enable = 1'b1;
            r.store_index  = '0;
            r.store_byte   = b;
        end else if (frame_open && rx_pos == LEN_HIGH_POS) begin
            frame_len = {b, len_lsb};
        end
        // Close the frame once the payload is complete
        if (frame_open && rx_pos >= LEN_HIGH_POS && frame_len == rx_pos - LEN_HIGH_POS) begin
            rx_pos     = '0;
            frame_open = 1'b0;
            frame_len  = '0;
            if (frame_cmd == CMD_RESET)
                r.reset_request = 1'b1;
            else if (frame_cmd == CMD_DONE)
                done_sticky = 1'b1;
            else
                ready_sticky = 1'b1;
        end
        rx_pos = rx_pos + 1'b1;
        r.frame_ready    = ready_sticky;
        r.download_done  = done_sticky;
        r.payload_length = frame_len;
        return r;
    endfunction

    function string show(input cfr_result_t r);
        return $sformatf("en=%0d idx=%0d byte=%02h rst=%0d rdy=%0d done=%0d len=%04h",
                         r.store_enable, r.store_index, r.store_byte, r.reset_request,
                         r.frame_ready, r.download_done, r.payload_length);
    endfunction

    // Send one byte, wait for its transaction, then log what it should cause
    task automatic send_byte(input logic [7:0] b, input bit pinned, input cfr_result_t pinned_res);
        cfr_result_t r;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        r = deframe_byte(b);
        deframed_q.push_back(pinned ? pinned_res : r);
        bytes_sent++;
    endtask

    task automatic send_plain(input logic [7:0] b);
        send_byte(b, 1'b0, '0);
    endtask

    always #10 clk = ~clk;

    // Result side: accept with random stall bursts
    initial begin
        res_if.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (idling_on && $urandom_range(0, 7) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Compare each result transaction against the oldest prediction
    always @(posedge clk) begin
        cfr_result_t got;
        cfr_result_t want;
        bit          same;
        if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got.store_enable   = res_if.store_enable;
            got.store_index    = res_if.store_index;
            got.store_byte     = res_if.store_byte;
            got.reset_request  = res_if.reset_request;
            got.frame_ready    = res_if.frame_ready;
            got.download_done  = res_if.download_done;
            got.payload_length = res_if.payload_length;
            if (deframed_q.size() == 0) begin
                bad_results++;
                if (bad_results <= MAX_REPORTS)
                    $display("%0t: unexpected result %s", $realtime, show(got));
            end else begin
                want = deframed_q.pop_front();
                same = got.store_enable === want.store_enable
                    && got.store_index === want.store_index
                    && got.store_byte === want.store_byte
                    && got.reset_request === want.reset_request
                    && got.frame_ready === want.frame_ready
                    && got.download_done === want.download_done
                    && got.payload_length === want.payload_length;
                if (!same) begin
                    bad_results++;
                    if (bad_results <= MAX_REPORTS)
                        $display("%0t: expected %s, got %s", $realtime, show(want), show(got));
                end
            end
        end
    end

    // Watchdog: give up when no transaction moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        int          base;
        int          next_switch;
        int          kind;
        int          n;
        logic [7:0]  cmd;
        logic [15:0] len;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed rows
        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].pinned, directed_rows[i].res);

        // Fill the open 0xFFFF frame up to the last memory index until the buffer
        // wraps; stay below the header byte so the wrapping byte opens nothing
        while (frame_open)
            send_plain(8'($urandom_range(0, 127)));

        // Random frames, noise and cut-short frames
        base = bytes_sent;
        next_switch = 0;
        while (bytes_sent < TOTAL_ITEMS) begin
            if (bytes_sent >= TOTAL_ITEMS - CALM_TAIL) begin
                idling_on = 1'b0;
            end else if (bytes_sent - base >= next_switch) begin
                idling_on = ($urandom_range(0, 3) != 0);
                next_switch += 100;
            end
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                n = $urandom_range(0, 9);
                cmd = (n < 2) ? CMD_RESET : (n < 4) ? CMD_DONE : 8'($urandom_range(0, 255));
                len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(13, 40))
                                                   : 16'($urandom_range(0, 12));
                send_plain(HDR_BYTE);
                send_plain(cmd);
                send_plain(len[7:0]);
                send_plain(len[15:8]);
                repeat (len)
                    send_plain(($urandom_range(0, 7) == 0) ? HDR_BYTE
                                                           : 8'($urandom_range(0, 255)));
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 8)) send_plain(8'($urandom_range(0, 255)));
            end else begin
                send_plain(HDR_BYTE);
                send_plain(8'($urandom_range(0, 255)));
                send_plain(8'($urandom_range(0, 255)));
                send_plain(8'h00);
                repeat ($urandom_range(0, 3)) send_plain(8'($urandom_range(0, 255)));
            end
        end

        // Drain and report
        rx_if.valid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_results == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
